// File: design/cau_pkg.sv
// shared types, constants and the clipping function of the complex arithmetic unit
// depends on nothing; every other file of the unit uses it by scoped names
package cau_pkg;

   localparam int DATA_W = 16;
   localparam int QUO_W  = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = 2 * DATA_W + 1;
   localparam int REM_W  = 2 * DATA_W + 1 + QUO_W;
   localparam int LIM_W  = 2 * DATA_W + 2;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  a_re;
      logic signed [DATA_W-1:0]  a_im;
      logic signed [DATA_W-1:0]  b_re;
      logic signed [DATA_W-1:0]  b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  res_re;
      logic signed [DATA_W-1:0]  res_im;
      logic                      saturated;
      logic                      div_by_zero;
   } rsp_type;

   // one item in flight through the divider stages
   typedef struct packed {
      logic               valid;
      logic               is_div;
      logic               neg_re;
      logic               neg_im;
      logic [REM_W-1:0]   rem_re;
      logic [REM_W-1:0]   rem_im;
      logic [PROD_W-1:0]  den;
      logic [QUO_W-1:0]   q_re;
      logic [QUO_W-1:0]   q_im;
      rsp_type            rsp;
   } div_type;

   // clip to the data range, top bit of the result is the clip flag
   function automatic logic [DATA_W:0] clip_fn(input logic signed [LIM_W-1:0] v);
      logic signed [LIM_W-1:0] hi;
      logic signed [LIM_W-1:0] lo;
      logic [DATA_W:0]         r;
      hi = LIM_W'((2 ** (DATA_W - 1)) - 1);
      lo = -hi - LIM_W'(1);
      if (v > hi) begin
         r = {1'b1, hi[DATA_W-1:0]};
      end else if (v < lo) begin
         r = {1'b1, lo[DATA_W-1:0]};
      end else begin
         r = {1'b0, v[DATA_W-1:0]};
      end
      return r;
   endfunction

endpackage

// File: design/cau_div_stage.sv
// one restoring division step for both result parts, with its pipeline register
// depends on cau_pkg
module cau_div_stage #(
   parameter int BIT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  cau_pkg::div_type stage_in,
   output cau_pkg::div_type stage_out
);

   logic [cau_pkg::REM_W-1:0] trial;
   cau_pkg::div_type          stage_in_d;
   cau_pkg::div_type          stage_ff;

   // subtract the shifted divisor where it fits and set the quotient bit
   always_comb begin
      trial      = cau_pkg::REM_W'(stage_in.den) << BIT;
      stage_in_d = stage_in;
      if (stage_in.rem_re >= trial) begin
         stage_in_d.rem_re    = stage_in.rem_re - trial;
         stage_in_d.q_re[BIT] = 1'b1;
      end
      if (stage_in.rem_im >= trial) begin
         stage_in_d.rem_im    = stage_in.rem_im - trial;
         stage_in_d.q_im[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in_d;
      end
   end

   assign stage_out = stage_ff;

endmodule

// File: design/complex_arithmetic_unit.sv
// complex add, subtract, multiply and divide on signed fixed point operands
// depends on cau_pkg and cau_div_stage
//
// usage: drive req_data and raise start for one cycle per item; busy is
// always low, so an item is taken at every edge where start is high.
// each item gives one result on rsp_data, marked by rsp_valid for
// exactly one cycle, after the item has passed the multiply stage, the sum
// stage, a prepare stage, 17 divider steps (one quotient bit each, both
// parts in parallel) and the output register. every mode runs the same
// path, so results leave in order.
// throughput: one item per cycle, limited by nothing but the clock.
// divide results truncate toward zero; multiply results round toward
// minus infinity; clipped parts raise saturated; divide by zero gives
// zero with div_by_zero set.
// reset clears the valid bits of every stage, so items in flight are
// dropped. the receiver cannot stall; results must be taken when shown.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   output cau_pkg::rsp_type rsp_data
);

   localparam int DW = cau_pkg::DATA_W;
   localparam int QW = cau_pkg::QUO_W;
   localparam int LAT = QW + 4;

   // stage 1: products and linear sums
   logic                             valid1_ff;
   cau_pkg::mode_type                mode1_ff;
   logic signed [cau_pkg::PROD_W-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff, p_cc_ff;
   logic signed [DW:0]               lin_re1_ff, lin_im1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= start;
      end
      mode1_ff <= req_data.mode;
      p_rr_ff  <= cau_pkg::PROD_W'(req_data.a_re) * cau_pkg::PROD_W'(req_data.b_re);
      p_ii_ff  <= cau_pkg::PROD_W'(req_data.a_im) * cau_pkg::PROD_W'(req_data.b_im);
      p_ir_ff  <= cau_pkg::PROD_W'(req_data.a_im) * cau_pkg::PROD_W'(req_data.b_re);
      p_ri_ff  <= cau_pkg::PROD_W'(req_data.b_im) * cau_pkg::PROD_W'(req_data.a_re);
      p_bb_ff  <= cau_pkg::PROD_W'(req_data.b_re) * cau_pkg::PROD_W'(req_data.b_re);
      p_cc_ff  <= cau_pkg::PROD_W'(req_data.b_im) * cau_pkg::PROD_W'(req_data.b_im);
      if (req_data.mode == cau_pkg::MODE_SUB) begin
         lin_re1_ff <= (DW+1)'(req_data.a_re) - (DW+1)'(req_data.b_re);
         lin_im1_ff <= (DW+1)'(req_data.a_im) - (DW+1)'(req_data.b_im);
      end else begin
         lin_re1_ff <= (DW+1)'(req_data.a_re) + (DW+1)'(req_data.b_re);
         lin_im1_ff <= (DW+1)'(req_data.a_im) + (DW+1)'(req_data.b_im);
      end
   end

   // stage 2: sums of products and the divisor
   logic                               valid2_ff;
   cau_pkg::mode_type                  mode2_ff;
   logic signed [cau_pkg::SUM_W-1:0]   num_re2_ff, num_im2_ff;
   logic [cau_pkg::PROD_W-1:0]         den2_ff;
   logic signed [DW:0]                 lin_re2_ff, lin_im2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      mode2_ff   <= mode1_ff;
      lin_re2_ff <= lin_re1_ff;
      lin_im2_ff <= lin_im1_ff;
      den2_ff    <= $unsigned(p_bb_ff) + $unsigned(p_cc_ff);
      if (mode1_ff == cau_pkg::MODE_MUL) begin
         num_re2_ff <= cau_pkg::SUM_W'(p_rr_ff) - cau_pkg::SUM_W'(p_ii_ff);
         num_im2_ff <= cau_pkg::SUM_W'(p_ir_ff) + cau_pkg::SUM_W'(p_ri_ff);
      end else begin
         num_re2_ff <= cau_pkg::SUM_W'(p_rr_ff) + cau_pkg::SUM_W'(p_ii_ff);
         num_im2_ff <= cau_pkg::SUM_W'(p_ir_ff) - cau_pkg::SUM_W'(p_ri_ff);
      end
   end

   // stage 3: finish the direct modes, set up the divider
   cau_pkg::div_type                 prep_in;
   cau_pkg::div_type                 prep_ff;
   logic signed [cau_pkg::LIM_W-1:0] wide_re, wide_im;
   logic [DW:0]                      clip_re, clip_im;
   logic [cau_pkg::SUM_W-1:0]        mag_re, mag_im;
   logic [cau_pkg::REM_W-1:0]        n_re, n_im, limit;
   logic                             ovf_re, ovf_im;

   always_comb begin
      wide_re = cau_pkg::LIM_W'(lin_re2_ff);
      wide_im = cau_pkg::LIM_W'(lin_im2_ff);
      if (mode2_ff == cau_pkg::MODE_MUL) begin
         wide_re = cau_pkg::LIM_W'(num_re2_ff) >>> FRAC_BITS;
         wide_im = cau_pkg::LIM_W'(num_im2_ff) >>> FRAC_BITS;
      end
      clip_re = cau_pkg::clip_fn(wide_re);
      clip_im = cau_pkg::clip_fn(wide_im);
      mag_re  = num_re2_ff[cau_pkg::SUM_W-1] ? $unsigned(-num_re2_ff) : $unsigned(num_re2_ff);
      mag_im  = num_im2_ff[cau_pkg::SUM_W-1] ? $unsigned(-num_im2_ff) : $unsigned(num_im2_ff);
      n_re    = cau_pkg::REM_W'(mag_re) << FRAC_BITS;
      n_im    = cau_pkg::REM_W'(mag_im) << FRAC_BITS;
      limit   = cau_pkg::REM_W'(den2_ff) << QW;
      ovf_re  = n_re >= limit;
      ovf_im  = n_im >= limit;

      prep_in.valid  = valid2_ff;
      prep_in.is_div = (mode2_ff == cau_pkg::MODE_DIV) && (den2_ff != '0);
      prep_in.neg_re = num_re2_ff[cau_pkg::SUM_W-1];
      prep_in.neg_im = num_im2_ff[cau_pkg::SUM_W-1];
      prep_in.den    = den2_ff;
      // an oversized quotient starts at all ones and clips the same way
      prep_in.rem_re = ovf_re ? '0 : n_re;
      prep_in.rem_im = ovf_im ? '0 : n_im;
      prep_in.q_re   = ovf_re ? '1 : '0;
      prep_in.q_im   = ovf_im ? '0 - 1'b1 : '0;
      prep_in.rsp.res_re      = clip_re[DW-1:0];
      prep_in.rsp.res_im      = clip_im[DW-1:0];
      prep_in.rsp.saturated   = clip_re[DW] | clip_im[DW];
      prep_in.rsp.div_by_zero = 1'b0;
      if (mode2_ff == cau_pkg::MODE_DIV) begin
         prep_in.rsp.res_re      = '0;
         prep_in.rsp.res_im      = '0;
         prep_in.rsp.saturated   = 1'b0;
         prep_in.rsp.div_by_zero = (den2_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff <= '0;
      end else begin
         prep_ff <= prep_in;
      end
   end

   // divider steps, most significant quotient bit first
   cau_pkg::div_type chain [QW+1];

   assign chain[0] = prep_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      cau_div_stage #(
         .BIT(QW - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   // sign the quotients, clip, and register the result
   cau_pkg::div_type                 last;
   logic signed [cau_pkg::LIM_W-1:0] qv_re, qv_im;
   logic [DW:0]                      qc_re, qc_im;
   cau_pkg::rsp_type                 rsp_in;
   cau_pkg::rsp_type                 rsp_ff;
   logic                             rsp_valid_ff;

   always_comb begin
      last  = chain[QW];
      qv_re = $signed(cau_pkg::LIM_W'(last.q_re));
      qv_im = $signed(cau_pkg::LIM_W'(last.q_im));
      if (last.neg_re) begin
         qv_re = -qv_re;
      end
      if (last.neg_im) begin
         qv_im = -qv_im;
      end
      qc_re  = cau_pkg::clip_fn(qv_re);
      qc_im  = cau_pkg::clip_fn(qv_im);
      rsp_in = last.rsp;
      if (last.is_div) begin
         rsp_in.res_re      = qc_re[DW-1:0];
         rsp_in.res_im      = qc_im[DW-1:0];
         rsp_in.saturated   = qc_re[DW] | qc_im[DW];
         rsp_in.div_by_zero = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // every result traces back to an item taken a fixed time before
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT) && !$past(reset, LAT))
      else $error("result without a matching item");

   // a divide by zero gives a clean zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_by_zero |->
         !rsp_data.saturated && rsp_data.res_re == '0 && rsp_data.res_im == '0)
      else $error("divide by zero result not zero");

   // only divide items may carry the divide by zero flag
   a_dz_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_data.mode != cau_pkg::MODE_DIV, LAT) |->
         !rsp_data.div_by_zero)
      else $error("divide by zero flag outside divide");
`endif

endmodule
